FILE: sv/assert_macros.svh
// assertion macros shared by the bank mapper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, checked outside reset
`define BSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: sv/bsm_pkg.sv
// shared types and constants of the bank switch mapper
package bsm_pkg;

  // fixed sizes
  localparam int PRG_BANK_BITS     = 4;
  localparam int CHR_PAGE_BITS_DEF = 7;
  localparam int OFFSET_BITS       = 17;
  localparam int APB_ADDR_BITS     = 4;
  localparam int APB_DATA_BITS     = 32;

  // actions
  localparam logic [1:0] ACT_CPU_WRITE = 2'd0;
  localparam logic [1:0] ACT_CPU_READ  = 2'd1;
  localparam logic [1:0] ACT_PPU_READ  = 2'd2;
  localparam logic [1:0] ACT_UNUSED    = 2'd3;

  // result targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_PRG  = 2'd1;
  localparam logic [1:0] TGT_CHR  = 2'd2;
  localparam logic [1:0] TGT_NT   = 2'd3;

  // board variants
  localparam logic [1:0] VAR_NORMAL    = 2'd0;
  localparam logic [1:0] VAR_FIXED_PRG = 2'd1;
  localparam logic [1:0] VAR_SPLIT_CHR = 2'd2;
  localparam logic [1:0] VAR_NT_SELECT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_VARIANT   = 2'd0;
  localparam logic [1:0] REG_VMIRROR   = 2'd1;
  localparam logic [1:0] REG_PRG_MASK  = 2'd2;
  localparam logic [1:0] REG_CHR_MASK  = 2'd3;

  // cpu address decode
  localparam logic [15:0] DEC_MASK     = 16'hE001;
  localparam logic [15:0] DEC_SELECT   = 16'h8000;
  localparam logic [15:0] DEC_LOAD     = 16'h8001;
  localparam logic [7:0]  SPLIT_OR     = 8'h40;

  // configuration seen by the bank logic
  typedef struct packed {
    logic [1:0]               variant;
    logic                     vertical_mirroring;
    logic [PRG_BANK_BITS-1:0] prg_bank_mask;
    logic [6:0]               chr_page_mask;
  } cfg_t;

endpackage

FILE: sv/bank_switch_mapper_108.sv
// Bank switch mapper: takes one bus access per item (cpu write, cpu read or ppu read) and
// returns one result per item, the target memory and byte offset, or none for writes, the
// unused action and cpu reads below 0x8000. One item is accepted every clock cycle unless
// stalled; the input register holds each item until the result register takes its result.
// Bank register updates from cpu writes take effect for the very next item. The rate is set
// by the single translation stage between the two registers. Configuration must be written
// through the apb port only while no item is in flight; the block does not enforce it.
module bank_switch_mapper_108 #(
  parameter int CHR_PAGE_BITS = bsm_pkg::CHR_PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [15:0]                       address,
  input  logic [7:0]                        write_data,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        target,
  output logic [bsm_pkg::OFFSET_BITS-1:0]   mapped_offset,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsm_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [bsm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bsm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  bsm_pkg::cfg_t                     cfg;

  logic                              s1_valid;
  logic [1:0]                        s1_action;
  logic [15:0]                       s1_address;
  logic [7:0]                        s1_write_data;

  logic                              out_free;
  logic                              s1_fire;
  logic                              in_accept;
  logic [1:0]                        target_next;
  logic [bsm_pkg::OFFSET_BITS-1:0]   mapped_offset_next;

  // configuration registers
  bsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // flow control
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action     <= action;
      s1_address    <= address;
      s1_write_data <= write_data;
    end
  end

  // bank state and translation
  bsm_bank #(
    .CHR_PAGE_BITS (CHR_PAGE_BITS)
  ) u_bank (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .upd_en        (s1_fire && (s1_action == bsm_pkg::ACT_CPU_WRITE)),
    .action        (s1_action),
    .address       (s1_address),
    .write_data    (s1_write_data),
    .target        (target_next),
    .mapped_offset (mapped_offset_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      target        <= target_next;
      mapped_offset <= mapped_offset_next;
    end
  end

  // checks
`include "assert_macros.svh"

  `BSM_ASSERT_NEXT(a_fire_gives_result, s1_fire, out_valid)
  `BSM_ASSERT_IMPL(a_stall_only_when_full, in_stall, s1_valid && out_valid && out_stall)
  `BSM_ASSERT_NEXT(a_write_has_no_target, s1_fire && (s1_action == bsm_pkg::ACT_CPU_WRITE),
                   (target == bsm_pkg::TGT_NONE) && (mapped_offset == '0))

endmodule

FILE: sv/bsm_cfg.sv
// apb configuration registers of the bank switch mapper
module bsm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsm_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [bsm_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [bsm_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output bsm_pkg::cfg_t                       cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.variant            <= bsm_pkg::VAR_NORMAL;
      cfg.vertical_mirroring <= 1'b0;
      cfg.prg_bank_mask      <= 4'd15;
      cfg.chr_page_mask      <= 7'd127;
    end else if (wr_en) begin
      unique case (reg_index)
        bsm_pkg::REG_VARIANT:  cfg.variant            <= pwdata[1:0];
        bsm_pkg::REG_VMIRROR:  cfg.vertical_mirroring <= pwdata[0];
        bsm_pkg::REG_PRG_MASK: cfg.prg_bank_mask      <= pwdata[3:0];
        bsm_pkg::REG_CHR_MASK: cfg.chr_page_mask      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_index)
      bsm_pkg::REG_VARIANT:  prdata = 32'(cfg.variant);
      bsm_pkg::REG_VMIRROR:  prdata = 32'(cfg.vertical_mirroring);
      bsm_pkg::REG_PRG_MASK: prdata = 32'(cfg.prg_bank_mask);
      bsm_pkg::REG_CHR_MASK: prdata = 32'(cfg.chr_page_mask);
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: sv/bsm_bank.sv
// bank registers and address translation of the bank switch mapper
module bsm_bank #(
  parameter int CHR_PAGE_BITS = bsm_pkg::CHR_PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bsm_pkg::cfg_t                       cfg,
  input  logic                                upd_en,
  input  logic [1:0]                          action,
  input  logic [15:0]                         address,
  input  logic [7:0]                          write_data,
  output logic [1:0]                          target,
  output logic [bsm_pkg::OFFSET_BITS-1:0]     mapped_offset
);

  logic [2:0]                          selected_register;
  logic [CHR_PAGE_BITS-1:0]            chr_window_page [8];
  logic [bsm_pkg::PRG_BANK_BITS-1:0]   prg_window_bank [2];
  logic                                nametable_page  [4];

  logic [15:0]                         dec;
  logic                                do_select;
  logic                                do_load;
  logic [5:0]                          pair_page;
  logic [7:0]                          single_page;
  logic [2:0]                          reg_sel;

  logic [bsm_pkg::PRG_BANK_BITS-1:0]   prg_bank;
  logic [7:0]                          chr_page;
  logic [13:0]                         ppu_addr;
  logic                                nt_page;

  // cpu write decode
  assign dec         = address & bsm_pkg::DEC_MASK;
  assign do_select   = upd_en && (dec == bsm_pkg::DEC_SELECT);
  assign do_load     = upd_en && (dec == bsm_pkg::DEC_LOAD);
  assign reg_sel     = selected_register;
  assign pair_page   = {write_data[5:1], 1'b0};
  assign single_page = {2'b00, write_data[5:0]} |
                       ((cfg.variant == bsm_pkg::VAR_SPLIT_CHR) ? bsm_pkg::SPLIT_OR : 8'h00);

  // bank register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      selected_register <= '0;
      for (int i = 0; i < 8; i++) begin
        chr_window_page[i] <= CHR_PAGE_BITS'(i);
      end
      prg_window_bank[0] <= '0;
      prg_window_bank[1] <= bsm_pkg::PRG_BANK_BITS'(1);
      for (int i = 0; i < 4; i++) begin
        nametable_page[i] <= 1'b0;
      end
    end else begin
      if (do_select) begin
        selected_register <= write_data[2:0];
      end
      if (do_load) begin
        priority if (reg_sel < 3'd2) begin
          chr_window_page[{1'b0, reg_sel[0], 1'b0}] <= CHR_PAGE_BITS'(8'(pair_page));
          chr_window_page[{1'b0, reg_sel[0], 1'b1}] <=
            CHR_PAGE_BITS'(8'(pair_page | 6'd1));
          if (cfg.variant == bsm_pkg::VAR_NT_SELECT) begin
            nametable_page[{reg_sel[0], 1'b0}] <= write_data[5];
            nametable_page[{reg_sel[0], 1'b1}] <= write_data[5];
          end
        end else if (reg_sel < 3'd6) begin
          chr_window_page[reg_sel + 3'd2] <= CHR_PAGE_BITS'(single_page);
        end else if (cfg.variant != bsm_pkg::VAR_FIXED_PRG) begin
          prg_window_bank[reg_sel[0]] <= write_data[3:0];
        end
      end
      // single-screen select on any write in rom space, split chr variant only
      if (upd_en && (cfg.variant == bsm_pkg::VAR_SPLIT_CHR) && address[15]) begin
        for (int i = 0; i < 4; i++) begin
          nametable_page[i] <= write_data[6];
        end
      end
    end
  end

  // prg bank per 8 KiB window, last two windows fixed
  always_comb begin
    unique case (address[14:13])
      2'd0:    prg_bank = prg_window_bank[0];
      2'd1:    prg_bank = prg_window_bank[1];
      2'd2:    prg_bank = cfg.prg_bank_mask - 4'd1;
      default: prg_bank = cfg.prg_bank_mask;
    endcase
  end

  assign ppu_addr = address[13:0];
  assign chr_page = 8'(chr_window_page[ppu_addr[12:10]]) & {1'b0, cfg.chr_page_mask};

  // nametable page by mirroring mode
  always_comb begin
    priority if (cfg.variant == bsm_pkg::VAR_SPLIT_CHR ||
                 cfg.variant == bsm_pkg::VAR_NT_SELECT) begin
      nt_page = nametable_page[ppu_addr[11:10]];
    end else if (cfg.vertical_mirroring) begin
      nt_page = ppu_addr[10];
    end else begin
      nt_page = ppu_addr[11];
    end
  end

  // address translation
  always_comb begin
    target        = bsm_pkg::TGT_NONE;
    mapped_offset = '0;
    unique case (action)
      bsm_pkg::ACT_CPU_READ: begin
        if (address[15]) begin
          target        = bsm_pkg::TGT_PRG;
          mapped_offset = {prg_bank & cfg.prg_bank_mask, address[12:0]};
        end
      end
      bsm_pkg::ACT_PPU_READ: begin
        if (!ppu_addr[13]) begin
          target        = bsm_pkg::TGT_CHR;
          mapped_offset = {chr_page[6:0], ppu_addr[9:0]};
        end else begin
          target        = bsm_pkg::TGT_NT;
          mapped_offset = {6'd0, nt_page, ppu_addr[9:0]};
        end
      end
      bsm_pkg::ACT_CPU_WRITE, bsm_pkg::ACT_UNUSED: begin
        target        = bsm_pkg::TGT_NONE;
        mapped_offset = '0;
      end
      default: ;
    endcase
  end

endmodule
